// ===== sv/tsrr_pkg.sv =====
`default_nettype none
package tsrr_pkg;

  localparam int READY_DEPTH_DEFAULT   = 16;
  localparam int BLOCKED_DEPTH_DEFAULT = 16;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SUSPEND = 3'd1;
  localparam logic [2:0] OP_RESUME  = 3'd2;
  localparam logic [2:0] OP_KILL    = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_IDLE_TICK = 3'd3;
  localparam logic [2:0] ST_SKIPPED   = 3'd4;

  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_PRIO = 2'd1;
  localparam logic [1:0] MODE_SJF  = 2'd2;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;

  localparam logic [11:0] QUANTUM_RESET = 12'd5;

  localparam logic [15:0] Q_MUL_SOLO = 16'd10;
  localparam logic [15:0] Q_MUL_LONG = 16'd3;
  localparam logic [15:0] Q_MUL_MID  = 16'd2;
  localparam logic [15:0] AVG_LONG   = 16'd100;
  localparam logic [15:0] AVG_MID    = 16'd40;
  localparam int          SMALL_N    = 4;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [15:0] rem;
  } task_t;

  function automatic logic [15:0] key_of(input task_t t, input logic [1:0] mode);
    key_of = (mode == MODE_PRIO) ? {8'd0, t.prio} : t.rem;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tsrr_cell.sv =====
`default_nettype none
module tsrr_cell
  import tsrr_pkg::*;
(
  input  wire         clk,
  input  wire         load,
  input  wire task_t  load_data,
  input  wire         shift,
  input  wire task_t  shift_data,
  input  wire  [15:0] pid_in,
  output task_t       data,
  output logic        match
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_data;
    end
  end

  assign match = (data.pid == pid_in);

endmodule
`default_nettype wire

// ===== sv/task_scheduler_rr_priority_sjf_unit.sv =====
`default_nettype none
// Task scheduler with round robin, priority and shortest-remaining-first policies. One
// result item is returned for every accepted input item. Suspending or killing the running
// task and a tick run the min-key scan in the keyed modes; the scan reads one ready cell
// per cycle, and a tick that completes or preempts a task may scan twice. The next item
// is accepted while a result waits in the output register.
module task_scheduler_rr_priority_sjf_unit
  import tsrr_pkg::*;
#(
  parameter int READY_DEPTH   = READY_DEPTH_DEFAULT,
  parameter int BLOCKED_DEPTH = BLOCKED_DEPTH_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [39:0]  s_tdata,   // task_pid, task_priority, task_remaining
  input  wire  [2:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [183:0] m_tdata,   // running_valid, running_pid, slice_valid, slice_pid,
                                  // slice_start, slice_length, effective_quantum,
                                  // dead_valid, dead_pid, context_switches, completions
  output logic [2:0]   m_tuser,   // status
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [11:0]  cfg_data
);

  localparam int IDXW  = $clog2(READY_DEPTH);
  localparam int CNTW  = $clog2(READY_DEPTH + 1);
  localparam int BIDXW = (BLOCKED_DEPTH > 1) ? $clog2(BLOCKED_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DSEL, S_SCAN, S_DISP, S_SLICE, S_PICK, S_FIN
  } state_t;

  state_t state, state_next, ret_st, ret_st_next, scan_nx, scan_nx_next;

  logic [1:0]  policy;
  logic [11:0] base_q;
  logic [2:0]  op_r, op_r_next;
  task_t       in_r, in_r_next;

  logic [CNTW-1:0]     count, count_next;
  logic [BLOCKED_DEPTH-1:0] bvalid, bvalid_next;
  task_t       cur, cur_next;
  logic        has, has_next;
  logic [31:0] cpu, cpu_next, sw, sw_next, comp, comp_next;
  logic [CNTW-1:0] scan_i, scan_i_next, best_i, best_i_next;
  logic [16:0] best_k, best_k_next;
  logic        extra, extra_next;

  logic [2:0]  st, st_next;
  logic        sv, sv_next, dv, dv_next;
  logic [15:0] spid, spid_next, slen, slen_next, seq, seq_next, dpid, dpid_next;
  logic [31:0] sstart, sstart_next;
  logic        out_valid, out_valid_next;
  logic [183:0] out_data, out_data_next;
  logic [2:0]  out_user, out_user_next;

  logic            rm_en, app_en, bwr_en;
  logic [CNTW-1:0] rm_idx, app_idx;
  task_t           app_data, bwr_data;
  logic [BIDXW-1:0] bwr_idx;
  logic [IDXW-1:0] rd_addr;

  task_t rq [READY_DEPTH];
  task_t bq [BLOCKED_DEPTH];
  logic [READY_DEPTH-1:0]   rmatch;
  logic [BLOCKED_DEPTH-1:0] bmatch;
  task_t rd_data;

  genvar g;
  generate
    for (g = 0; g < READY_DEPTH; g++) begin : g_ready
      task_t nb;
      if (g < READY_DEPTH - 1) begin : g_mid
        assign nb = rq[g+1];
      end else begin : g_end
        assign nb = '0;
      end
      tsrr_cell u_cell (
        .clk(clk),
        .load(app_en && (app_idx == CNTW'(g))),
        .load_data(app_data),
        .shift(rm_en && (CNTW'(g) >= rm_idx) && (CNTW'(g + 1) < count)),
        .shift_data(nb),
        .pid_in(in_r.pid),
        .data(rq[g]),
        .match(rmatch[g])
      );
    end
    for (g = 0; g < BLOCKED_DEPTH; g++) begin : g_blocked
      tsrr_cell u_cell (
        .clk(clk),
        .load(bwr_en && (bwr_idx == BIDXW'(g))),
        .load_data(bwr_data),
        .shift(1'b0),
        .shift_data('0),
        .pid_in(in_r.pid),
        .data(bq[g]),
        .match(bmatch[g])
      );
    end
  endgenerate

  // First-match searches over the cells.
  logic            rfound, bfound, bfree;
  logic [IDXW-1:0] ridx;
  logic [BIDXW-1:0] bidx, fslot;
  always_comb begin
    rfound = 1'b0;
    ridx   = '0;
    bfound = 1'b0;
    bidx   = '0;
    bfree  = 1'b0;
    fslot  = '0;
    for (int i = READY_DEPTH - 1; i >= 0; i--) begin
      if (rmatch[i] && (CNTW'(i) < count)) begin
        rfound = 1'b1;
        ridx   = IDXW'(i);
      end
    end
    for (int i = BLOCKED_DEPTH - 1; i >= 0; i--) begin
      if (bvalid[i] && bmatch[i]) begin
        bfound = 1'b1;
        bidx   = BIDXW'(i);
      end
      if (!bvalid[i]) begin
        bfree = 1'b1;
        fslot = BIDXW'(i);
      end
    end
  end

  assign rd_data = rq[rd_addr];

  logic        keyed, cur_match;
  logic [16:0] k_scan, nb_k, sum17;
  logic [CNTW-1:0] nb_i;
  logic [15:0] eq, run, avg;
  logic [15:0] bq16;
  assign keyed     = (policy == MODE_PRIO) || (policy == MODE_SJF);
  assign cur_match = has && (cur.pid == in_r.pid);
  assign bq16      = {4'd0, base_q};

  always_comb begin
    state_next   = state;
    ret_st_next  = ret_st;
    scan_nx_next = scan_nx;
    op_r_next    = op_r;
    in_r_next    = in_r;
    count_next   = count;
    bvalid_next  = bvalid;
    cur_next     = cur;
    has_next     = has;
    cpu_next     = cpu;
    sw_next      = sw;
    comp_next    = comp;
    scan_i_next  = scan_i;
    best_i_next  = best_i;
    best_k_next  = best_k;
    extra_next   = extra;
    st_next      = st;
    sv_next      = sv;
    spid_next    = spid;
    sstart_next  = sstart;
    slen_next    = slen;
    seq_next     = seq;
    dv_next      = dv;
    dpid_next    = dpid;
    out_valid_next = out_valid && !m_tready;
    out_data_next  = out_data;
    out_user_next  = out_user;
    rm_en    = 1'b0;
    rm_idx   = '0;
    app_en   = 1'b0;
    app_idx  = '0;
    app_data = '0;
    bwr_en   = 1'b0;
    bwr_idx  = '0;
    bwr_data = '0;
    rd_addr  = '0;
    k_scan   = '0;
    nb_k     = '0;
    nb_i     = '0;
    sum17    = '0;
    avg      = '0;
    eq       = '0;
    run      = '0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_r_next   = s_tuser;
          in_r_next   = '{pid: s_tdata[15:0], prio: s_tdata[23:16], rem: s_tdata[39:24]};
          st_next     = ST_OK;
          sv_next     = 1'b0;
          spid_next   = '0;
          sstart_next = '0;
          slen_next   = '0;
          seq_next    = '0;
          dv_next     = 1'b0;
          dpid_next   = '0;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_addr    = ridx;
        state_next = S_FIN;
        case (op_r)
          OP_ADD: begin
            if (count >= CNTW'(READY_DEPTH)) begin
              st_next = ST_FULL;
            end else begin
              app_en     = 1'b1;
              app_idx    = count;
              app_data   = in_r;
              count_next = count + CNTW'(1);
            end
          end
          OP_SUSPEND: begin
            if (cur_match) begin
              if (!bfree) begin
                st_next = ST_FULL;
              end else begin
                bwr_en   = 1'b1;
                bwr_idx  = fslot;
                bwr_data = cur;
                bvalid_next[fslot] = 1'b1;
                has_next    = 1'b0;
                ret_st_next = S_FIN;
                state_next  = S_DSEL;
              end
            end else if (rfound) begin
              if (!bfree) begin
                st_next = ST_FULL;
              end else begin
                bwr_en   = 1'b1;
                bwr_idx  = fslot;
                bwr_data = rd_data;
                bvalid_next[fslot] = 1'b1;
                rm_en      = 1'b1;
                rm_idx     = CNTW'(ridx);
                count_next = count - CNTW'(1);
              end
            end else begin
              st_next = ST_NOT_FOUND;
            end
          end
          OP_RESUME: begin
            if (!bfound) begin
              st_next = ST_NOT_FOUND;
            end else if (count >= CNTW'(READY_DEPTH)) begin
              st_next = ST_FULL;
            end else begin
              app_en     = 1'b1;
              app_idx    = count;
              app_data   = bq[bidx];
              count_next = count + CNTW'(1);
              bvalid_next[bidx] = 1'b0;
            end
          end
          OP_KILL: begin
            if (cur_match) begin
              has_next    = 1'b0;
              comp_next   = comp + 32'd1;
              dv_next     = 1'b1;
              dpid_next   = in_r.pid;
              ret_st_next = S_FIN;
              state_next  = S_DSEL;
            end else if (rfound) begin
              rm_en      = 1'b1;
              rm_idx     = CNTW'(ridx);
              count_next = count - CNTW'(1);
              dv_next    = 1'b1;
              dpid_next  = in_r.pid;
            end else if (bfound) begin
              bvalid_next[bidx] = 1'b0;
              dv_next   = 1'b1;
              dpid_next = in_r.pid;
            end else begin
              st_next = ST_NOT_FOUND;
            end
          end
          OP_TICK: begin
            if ((count == '0) && !has) begin
              st_next = ST_IDLE_TICK;
            end else if (!has) begin
              ret_st_next = S_SLICE;
              state_next  = S_DSEL;
            end else begin
              state_next = S_SLICE;
            end
          end
          default: begin
            st_next = ST_OK;
          end
        endcase
      end
      S_DSEL: begin
        if (count == '0) begin
          state_next = ret_st;
        end else if (keyed) begin
          scan_i_next  = '0;
          best_i_next  = '0;
          best_k_next  = '1;
          extra_next   = 1'b0;
          scan_nx_next = S_DISP;
          state_next   = S_SCAN;
        end else begin
          best_i_next = '0;
          state_next  = S_DISP;
        end
      end
      S_SCAN: begin
        rd_addr = scan_i[IDXW-1:0];
        k_scan  = {1'b0, key_of(rd_data, policy)};
        if (k_scan < best_k) begin
          nb_k = k_scan;
          nb_i = scan_i;
        end else begin
          nb_k = best_k;
          nb_i = best_i;
        end
        if (scan_i + CNTW'(1) == count) begin
          if (extra && ({1'b0, key_of(cur, policy)} < nb_k)) begin
            best_i_next = count;
          end else begin
            best_i_next = nb_i;
          end
          state_next = scan_nx;
        end else begin
          scan_i_next = scan_i + CNTW'(1);
          best_k_next = nb_k;
          best_i_next = nb_i;
        end
      end
      S_DISP: begin
        rd_addr    = best_i[IDXW-1:0];
        cur_next   = rd_data;
        rm_en      = 1'b1;
        rm_idx     = best_i;
        count_next = count - CNTW'(1);
        has_next   = 1'b1;
        sw_next    = sw + 32'd1;
        state_next = ret_st;
      end
      S_SLICE: begin
        rd_addr = '0;
        sum17   = {1'b0, cur.rem} + {1'b0, rd_data.rem};
        avg     = sum17[16:1];
        if (keyed) begin
          eq = cur.rem;
        end else if (count == '0) begin
          eq = bq16 * Q_MUL_SOLO;
        end else if (count == CNTW'(1)) begin
          if (avg > AVG_LONG) begin
            eq = bq16 * Q_MUL_LONG;
          end else if (avg > AVG_MID) begin
            eq = bq16 * Q_MUL_MID;
          end else begin
            eq = bq16;
          end
        end else if (count <= CNTW'(SMALL_N - 1)) begin
          eq = bq16 * Q_MUL_MID;
        end else begin
          eq = bq16;
        end
        run          = (eq < cur.rem) ? eq : cur.rem;
        sv_next      = 1'b1;
        spid_next    = cur.pid;
        sstart_next  = cpu;
        slen_next    = run;
        seq_next     = eq;
        cpu_next     = cpu + {16'd0, run};
        cur_next.rem = cur.rem - run;
        if (cur.rem == run) begin
          comp_next   = comp + 32'd1;
          dv_next     = 1'b1;
          dpid_next   = cur.pid;
          has_next    = 1'b0;
          ret_st_next = S_FIN;
          state_next  = S_DSEL;
        end else if (count == '0) begin
          st_next    = ST_SKIPPED;
          state_next = S_FIN;
        end else if (keyed) begin
          scan_i_next  = '0;
          best_i_next  = '0;
          best_k_next  = '1;
          extra_next   = 1'b1;
          scan_nx_next = S_PICK;
          state_next   = S_SCAN;
        end else begin
          best_i_next = '0;
          state_next  = S_PICK;
        end
      end
      S_PICK: begin
        rd_addr = best_i[IDXW-1:0];
        if (best_i < count) begin
          rm_en    = 1'b1;
          rm_idx   = best_i;
          app_en   = 1'b1;
          app_idx  = count - CNTW'(1);
          app_data = cur;
          cur_next = rd_data;
        end
        sw_next    = sw + 32'd1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_user_next  = st;
          out_data_next  = {5'd0, comp, sw, dpid, dv, seq, slen, sstart, spid, sv,
                            (has ? cur.pid : 16'd0), has};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_st    <= S_FIN;
      scan_nx   <= S_DISP;
      count     <= '0;
      bvalid    <= '0;
      has       <= 1'b0;
      cpu       <= '0;
      sw        <= '0;
      comp      <= '0;
      out_valid <= 1'b0;
      policy    <= MODE_RR;
      base_q    <= QUANTUM_RESET;
    end else begin
      state     <= state_next;
      ret_st    <= ret_st_next;
      scan_nx   <= scan_nx_next;
      count     <= count_next;
      bvalid    <= bvalid_next;
      has       <= has_next;
      cpu       <= cpu_next;
      sw        <= sw_next;
      comp      <= comp_next;
      out_valid <= out_valid_next;
      if (cfg_valid && (cfg_index == CFG_POLICY)) begin
        policy <= cfg_data[1:0];
      end
      if (cfg_valid && (cfg_index == CFG_QUANTUM)) begin
        base_q <= cfg_data;
      end
    end
    op_r     <= op_r_next;
    in_r     <= in_r_next;
    cur      <= cur_next;
    scan_i   <= scan_i_next;
    best_i   <= best_i_next;
    best_k   <= best_k_next;
    extra    <= extra_next;
    st       <= st_next;
    sv       <= sv_next;
    spid     <= spid_next;
    sstart   <= sstart_next;
    slen     <= slen_next;
    seq      <= seq_next;
    dv       <= dv_next;
    dpid     <= dpid_next;
    out_data <= out_data_next;
    out_user <= out_user_next;
  end

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign m_tuser   = out_user;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== sv/tsrr_checker.sv =====
`default_nettype none
module tsrr_checker
  import tsrr_pkg::*;
(
  input wire         clk,
  input wire         rst,
  input wire         s_tready,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [183:0] m_tdata,
  input wire [2:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("block not empty and ready after reset");

  a_slice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> m_tdata[81:66] <= m_tdata[97:82])
    else $error("slice longer than its quantum");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[17] |-> (m_tdata[97:18] == 80'd0) && (m_tuser != ST_SKIPPED))
    else $error("slice fields set without a slice");

endmodule

bind task_scheduler_rr_priority_sjf_unit tsrr_checker u_tsrr_checker (.*);
`default_nettype wire
